@@ rtl/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types, constants and helpers for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int DeltaBytesDefault = 4;
    localparam int DeltaW            = 28;

    localparam logic [7:0] MetaMarker = 8'hFF;
    localparam logic [7:0] StatusBit  = 8'b1000_0000;
    localparam logic [7:0] SysNibble  = 8'hF0;

    // parse phases
    typedef enum logic [2:0] {
        PH_DELTA     = 3'd0,
        PH_STATUS    = 3'd1,
        PH_META_TYPE = 3'd2,
        PH_META_LEN  = 3'd3,
        PH_DATA      = 3'd4
    } t_phase;

    // event kinds
    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_SYSTEM  = 2'd1,
        KIND_META    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [DeltaW-1:0] delta_time;
        t_kind             event_kind;
        logic [7:0]        event_code;
        logic [7:0]        data_byte;
        logic [7:0]        data_index;
        logic              has_data;
        logic              last;
        logic              delta_overflow;
    } t_result;

    // number of data bytes following a non-meta status
    function automatic logic [1:0] data_len_for(input logic [7:0] code);
        logic [1:0] len;
        len = 2'd2;
        if ((code & SysNibble) == SysNibble) begin
            case (code)
                8'hF2:   len = 2'd2;
                8'hF3:   len = 2'd1;
                default: len = 2'd0;
            endcase
        end else if (code[7:4] == 4'hC || code[7:4] == 4'hD) begin
            len = 2'd1;
        end
        return len;
    endfunction

    function automatic t_kind kind_of(input logic [7:0] code);
        return ((code & SysNibble) == SysNibble) ? KIND_SYSTEM : KIND_CHANNEL;
    endfunction

endpackage

@@ rtl/midi_track_event_parser_unit.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// Splits a standard MIDI file track byte stream into events, one result per
// data byte, or one data-less result for an event with no data bytes.
// ----------------------------------------------------------------------------
// The block takes one track byte per cycle while the input is not stalled:
// every byte is a single phase update done between the parse state
// registers and the result register, so a byte can be accepted on each
// clock unless stalled. Each event starts with a variable-length delta time (seven
// bits per byte, MSB group first); then comes a meta event (0xFF, type,
// one-byte length), a status byte (which also becomes the running status),
// or a data byte that reuses the running status (zero after reset). One
// result transaction is produced per data byte; an event with no data
// bytes produces a single data-less result with o_last set. Results sit in
// one output register; the input stalls only when that register is full
// and the downstream side stalls. Results are registered and appear in the
// cycle after the byte that causes them. Delta bytes past DELTA_BYTES set o_delta_overflow
// for the whole event, and only the low 28 bits of the delta are kept. A
// data byte under a running status with no data (a system code) gives a
// data-less result and is then reused as the first delta byte of the next
// event.
module midi_track_event_parser_unit #(
    parameter int DELTA_BYTES = mtep_pkg::DeltaBytesDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_byte_in,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mtep_pkg::DeltaW-1:0] o_delta_time,
    output logic [1:0]                  o_event_kind,
    output logic [7:0]                  o_event_code,
    output logic [7:0]                  o_data_byte,
    output logic [7:0]                  o_data_index,
    output logic                        o_has_data,
    output logic                        o_last,
    output logic                        o_delta_overflow
);
    import mtep_pkg::*;

    localparam int CntW = $clog2(DELTA_BYTES + 1);

    // parse state
    t_phase            r_phase,    n_phase;
    logic [DeltaW-1:0] r_acc,      n_acc;
    logic [CntW-1:0]   r_cnt,      n_cnt;
    logic              r_ovf,      n_ovf;
    logic [7:0]        r_rstat,    n_rstat;
    t_kind             r_kind,     n_kind;
    logic [7:0]        r_code,     n_code;
    logic [7:0]        r_rem,      n_rem;
    logic [7:0]        r_pos,      n_pos;

    // result register
    logic              r_out_valid;
    t_result           r_out;

    logic              accept;
    logic              out_take;
    logic              emit;
    t_result           emit_res;

    assign out_take   = r_out_valid && !i_out_stall;
    // input only waits when the result slot is full and not draining
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // one byte of parse work
    always_comb begin
        logic [7:0] b;
        logic [1:0] len;
        logic       do_data;
        logic [7:0] rem_cur;
        logic [7:0] pos_cur;
        logic [7:0] rem_dec;
        logic       end_evt;

        b        = i_byte_in;
        len      = 2'd0;
        do_data  = 1'b0;
        rem_cur  = r_rem;
        pos_cur  = r_pos;
        rem_dec  = 8'd0;
        end_evt  = 1'b0;
        emit     = 1'b0;
        emit_res = '0;

        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_rstat  = r_rstat;
        n_kind   = r_kind;
        n_code   = r_code;
        n_rem    = r_rem;
        n_pos    = r_pos;

        unique case (r_phase)
            PH_DELTA: begin
                if (r_cnt >= CntW'(DELTA_BYTES)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
                n_acc = {r_acc[DeltaW-8:0], b[6:0]};
                if ((b & StatusBit) == 8'd0) begin
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b == MetaMarker) begin
                    n_kind  = KIND_META;
                    n_phase = PH_META_TYPE;
                end else if ((b & StatusBit) != 8'd0) begin
                    n_rstat = b;
                    n_code  = b;
                    n_kind  = kind_of(b);
                    len     = data_len_for(b);
                    if (len == 2'd0) begin
                        emit    = 1'b1;
                        end_evt = 1'b1;
                    end else begin
                        n_rem   = {6'd0, len};
                        n_pos   = 8'd0;
                        n_phase = PH_DATA;
                    end
                end else begin
                    // data byte under running status
                    n_code = r_rstat;
                    n_kind = kind_of(r_rstat);
                    len    = data_len_for(r_rstat);
                    if (len == 2'd0) begin
                        emit    = 1'b1;
                        end_evt = 1'b1;
                    end else begin
                        do_data = 1'b1;
                        rem_cur = {6'd0, len};
                        pos_cur = 8'd0;
                    end
                end
            end
            PH_META_TYPE: begin
                n_code  = b;
                n_phase = PH_META_LEN;
            end
            PH_META_LEN: begin
                if (b == 8'd0) begin
                    emit    = 1'b1;
                    end_evt = 1'b1;
                end else begin
                    n_rem   = b;
                    n_pos   = 8'd0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                do_data = 1'b1;
            end
            default: begin
                end_evt = 1'b1;
            end
        endcase

        if (do_data) begin
            rem_dec             = (rem_cur != 8'd0) ? rem_cur - 8'd1 : 8'd0;
            emit                = 1'b1;
            emit_res.has_data   = 1'b1;
            emit_res.data_byte  = b;
            emit_res.data_index = pos_cur;
            if (rem_dec == 8'd0) begin
                end_evt = 1'b1;
            end else begin
                n_rem   = rem_dec;
                n_pos   = pos_cur + 8'd1;
                n_phase = PH_DATA;
            end
        end

        emit_res.delta_time     = r_acc;
        emit_res.event_kind     = n_kind;
        emit_res.event_code     = n_code;
        emit_res.last           = end_evt;
        emit_res.delta_overflow = r_ovf;

        if (end_evt) begin
            n_phase = PH_DELTA;
            n_acc   = '0;
            n_cnt   = '0;
            n_ovf   = 1'b0;
            n_rem   = 8'd0;
            n_pos   = 8'd0;
            // system running status with no data: byte opens the next delta
            if (r_phase == PH_STATUS && !do_data && (b & StatusBit) == 8'd0) begin
                n_acc   = {{(DeltaW-7){1'b0}}, b[6:0]};
                n_cnt   = CntW'(1);
                n_phase = PH_STATUS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_rstat <= 8'd0;
            r_kind  <= KIND_CHANNEL;
            r_code  <= 8'd0;
            r_rem   <= 8'd0;
            r_pos   <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_rstat <= n_rstat;
            r_kind  <= n_kind;
            r_code  <= n_code;
            r_rem   <= n_rem;
            r_pos   <= n_pos;
        end
    end

    // result register: loads on a producing byte, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= emit_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_delta_time     = r_out.delta_time;
    assign o_event_kind     = r_out.event_kind;
    assign o_event_code     = r_out.event_code;
    assign o_data_byte      = r_out.data_byte;
    assign o_data_index     = r_out.data_index;
    assign o_has_data       = r_out.has_data;
    assign o_last           = r_out.last;
    assign o_delta_overflow = r_out.delta_overflow;

`ifndef ASSERT_OFF
    // input is only held off by a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    // a data-less result always closes its event
    a_nodata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_data) |-> o_last)
        else $error("data-less result not marked last");

    // data-less results carry zero data and index
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_data) |-> (o_data_byte == 8'd0 && o_data_index == 8'd0))
        else $error("data-less result with nonzero data fields");

    // an accepted producing byte always fills the result register
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && emit) |=> o_out_valid)
        else $error("producing byte did not fill result register");
`endif

endmodule
